FILE: rtl/srr_pkg.sv
// ---------------------------------------------------------------------------
// srr_pkg
// Shared types, widths and codes of the selective-repeat receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

   localparam int MAX_WINDOW  = 16;
   localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CFG_W       = 5;
   localparam int SEQ_W       = 32;
   localparam int HANDLE_W    = 16;
   localparam int LEN_W       = 11;
   localparam int MAX_RESULTS = 19;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int STEP_W      = $clog2(SEQ_W + 1);

   localparam logic [LEN_W-1:0] PAYLOAD_MAX = LEN_W'(1400);
   localparam logic [CFG_W-1:0] WINDOW_RST  = CFG_W'(16);

   // result kinds
   localparam logic [2:0] RES_DELIVER = 3'd0;
   localparam logic [2:0] RES_RR      = 3'd1;
   localparam logic [2:0] RES_SREJ    = 3'd2;
   localparam logic [2:0] RES_EOFACK  = 3'd3;
   localparam logic [2:0] RES_TIMEOUT = 3'd4;

   // input kinds
   localparam logic KIND_PACKET  = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // csr register indexes
   localparam logic REG_WINDOW = 1'b0;

   typedef struct packed {
      logic [2:0]          kind;
      logic [SEQ_W-1:0]    number;
      logic [SEQ_W-1:0]    ctrl;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    len;
   } result_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [IDX_W-1:0] rem;
   } rem_stat_type;

   // register value clamped to 1..MAX_WINDOW
   function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] win);
      logic [WIN_W-1:0] w;
      if (win == '0) begin
         w = WIN_W'(1);
      end else if (32'(win) > MAX_WINDOW) begin
         w = WIN_W'(MAX_WINDOW);
      end else begin
         w = WIN_W'(win);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/srr_rem.sv
// ---------------------------------------------------------------------------
// srr_rem
// Bit-serial remainder of a 32-bit sequence number by the window size,
// one dividend bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_rem
   import srr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SEQ_W-1:0] dividend,
   input  wire logic [WIN_W-1:0] divisor,
   output rem_stat_type          stat
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SEQ_W-1:0]  quo_ff, quo_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [WIN_W:0]    trial;
   logic [WIN_W:0]    trial_sub;

   always_comb begin
      trial     = {rem_ff, quo_ff[SEQ_W-1]};
      trial_sub = (trial >= (WIN_W+1)'(divisor)) ? trial - (WIN_W+1)'(divisor) : trial;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SEQ_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = trial_sub[WIN_W-1:0];
         quo_in  = {quo_ff[SEQ_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.rem  = rem_ff[IDX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/selective_repeat_receiver.sv
// ---------------------------------------------------------------------------
// selective_repeat_receiver
// Receive side of a selective-repeat ARQ: delivery, window store, RR/SREJ.
// ---------------------------------------------------------------------------
// One item is handled at a time. A sequencer emits at most one result per
// cycle: an in-order packet steps through evaluate, RR, EOF check and close,
// an old packet adds an SREJ step, and each slot flushed from the window store
// adds the store's synchronous read, then the deliver beat. Output
// back-pressure stretches every result step. A write of window_size recomputes
// expected mod window serially, during which req_tready stays low. The last
// result beat of an item carries rsp_tlast; an item may yield no beat at all.
`default_nettype none

module selective_repeat_receiver
   import srr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: one received packet header or timeout tick per beat
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // seq_num[31:0], payload_handle, payload_len
   input  wire logic        req_tlast,  // is_eof
   input  wire logic [1:0]  req_tuser,  // kind, checksum_ok
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,  // number, ctrl_seq, out_handle, out_len
   output logic             rsp_tlast,  // last
   output logic [2:0]       rsp_tuser,  // result_kind
   // csr
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EVAL   = 4'd1;
   localparam logic [3:0] S_SREJ   = 4'd2;
   localparam logic [3:0] S_RR     = 4'd3;
   localparam logic [3:0] S_RR_CLR = 4'd4;
   localparam logic [3:0] S_FL_CHK = 4'd5;
   localparam logic [3:0] S_FL_RD  = 4'd6;
   localparam logic [3:0] S_EOF    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam logic [IDX_W-1:0] EXP_MOD_RST = (MAX_WINDOW > 1) ? IDX_W'(1) : '0;

   logic [3:0]          state_ff, state_in;
   logic [SEQ_W-1:0]    exp_ff, exp_in;
   logic [SEQ_W-1:0]    hi_ff, hi_in;
   logic [SEQ_W-1:0]    ctr_ff, ctr_in;
   logic                buf_ff, buf_in;
   logic                eofs_ff, eofs_in;
   logic                fin_ff, fin_in;
   logic                flush_ff, flush_in;
   logic [IDX_W-1:0]    exp_mod_ff, exp_mod_in;
   logic [MAX_WINDOW-1:0] valid_ff, valid_in;
   logic [CFG_W-1:0]    win_ff;
   logic                rem_start_ff;

   logic                it_kind_ff, it_eof_ff, it_ok_ff;
   logic [SEQ_W-1:0]    it_seq_ff;
   logic [HANDLE_W-1:0] it_handle_ff;
   logic [LEN_W-1:0]    it_len_ff;

   logic [HANDLE_W+LEN_W-1:0] slot_mem [MAX_WINDOW];
   logic [HANDLE_W+LEN_W-1:0] rd_data_ff;

   logic                pend_valid_ff, pend_valid_in;
   result_type          pend_ff, pend_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_accept;
   logic                cfg_we;
   logic                emit_ok;
   logic                produce;
   logic                finish;
   result_type          prod_res;
   logic                mem_we, mem_re;
   logic [WIN_W-1:0]    eff;
   logic [LEN_W-1:0]    len_sat;
   logic                seq_eq, seq_ahead, in_win;
   logic [SEQ_W-1:0]    gap;
   logic [WIN_W:0]      slot_sum, slot_adj;
   logic [IDX_W-1:0]    slot_idx;
   logic [WIN_W-1:0]    mod_step;
   logic [IDX_W-1:0]    mod_inc;
   rem_stat_type        rem_stat;

   // ------------------------------------------------------------------ csr
   assign cfg_we     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == REG_WINDOW);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW) ? 32'(win_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_RST;
         rem_start_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            win_ff <= csr_pwdata[CFG_W-1:0];
         end
         rem_start_ff <= cfg_we;
      end
   end

   assign eff = eff_window(win_ff);

   srr_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start_ff),
      .dividend (exp_ff),
      .divisor  (eff),
      .stat     (rem_stat)
   );

   // ------------------------------------------------------------------ item
   assign req_tready = (state_ff == S_IDLE) & ~rem_stat.busy & ~rem_start_ff;
   assign req_accept = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         it_kind_ff   <= req_tuser[0];
         it_ok_ff     <= req_tuser[1];
         it_eof_ff    <= req_tlast;
         it_seq_ff    <= req_tdata[31:0];
         it_handle_ff <= req_tdata[47:32];
         it_len_ff    <= req_tdata[58:48];
      end
   end

   assign len_sat   = (it_len_ff > PAYLOAD_MAX) ? PAYLOAD_MAX : it_len_ff;
   assign seq_eq    = (it_seq_ff == exp_ff);
   assign seq_ahead = (it_seq_ff > exp_ff);
   assign gap       = it_seq_ff - exp_ff;
   assign in_win    = (gap < SEQ_W'(eff));

   // slot of a packet ahead: (expected mod w + gap) mod w, gap < w
   assign slot_sum = (WIN_W+1)'(exp_mod_ff) + (WIN_W+1)'(gap[WIN_W-1:0]);
   assign slot_adj = (slot_sum >= (WIN_W+1)'(eff)) ? slot_sum - (WIN_W+1)'(eff) : slot_sum;
   assign slot_idx = slot_adj[IDX_W-1:0];

   // expected + 1 mod w; 2^32 wrap restarts the residue at zero
   assign mod_step = WIN_W'(exp_mod_ff) + 1'b1;
   assign mod_inc  = ((exp_ff == '1) || (mod_step == eff)) ? '0 : mod_step[IDX_W-1:0];

   assign emit_ok = ~rsp_valid_ff | rsp_tready;

   // ------------------------------------------------------------------ sequencer
   always_comb begin
      state_in   = state_ff;
      exp_in     = exp_ff;
      hi_in      = hi_ff;
      ctr_in     = ctr_ff;
      buf_in     = buf_ff;
      eofs_in    = eofs_ff;
      fin_in     = fin_ff;
      flush_in   = flush_ff;
      exp_mod_in = exp_mod_ff;
      valid_in   = valid_ff;
      produce    = 1'b0;
      prod_res   = '0;
      finish     = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EVAL;
            end
         end
         default: begin
            if (emit_ok) begin
               case (state_ff)
                  S_EVAL: begin
                     state_in = S_DONE;
                     flush_in = 1'b0;
                     if (fin_ff) begin
                        state_in = S_DONE;
                     end else if (it_kind_ff == KIND_TIMEOUT) begin
                        produce       = 1'b1;
                        prod_res.kind = RES_TIMEOUT;
                        fin_in        = 1'b1;
                     end else if (!it_ok_ff || (seq_ahead && !in_win)) begin
                        state_in = S_DONE;
                     end else begin
                        eofs_in = eofs_ff | it_eof_ff;
                        if (seq_eq) begin
                           produce         = 1'b1;
                           prod_res.kind   = RES_DELIVER;
                           prod_res.number = it_seq_ff;
                           prod_res.handle = it_handle_ff;
                           prod_res.len    = len_sat;
                           if (exp_ff > hi_ff) begin
                              hi_in = exp_ff;
                           end
                           exp_in     = exp_ff + 1'b1;
                           exp_mod_in = mod_inc;
                           if (buf_ff) begin
                              flush_in = 1'b1;
                              state_in = S_FL_CHK;
                           end else begin
                              state_in = S_RR;
                           end
                        end else if (seq_ahead) begin
                           mem_we             = 1'b1;
                           valid_in[slot_idx] = 1'b1;
                           if (it_seq_ff > hi_ff) begin
                              hi_in = it_seq_ff;
                           end
                           if (!buf_ff) begin
                              produce         = 1'b1;
                              prod_res.kind   = RES_SREJ;
                              prod_res.number = exp_ff;
                              prod_res.ctrl   = ctr_ff;
                              ctr_in          = ctr_ff + 1'b1;
                              buf_in          = 1'b1;
                           end
                        end else begin
                           state_in = S_SREJ;
                        end
                     end
                  end
                  S_SREJ: begin
                     produce         = 1'b1;
                     prod_res.kind   = RES_SREJ;
                     prod_res.number = exp_ff;
                     prod_res.ctrl   = ctr_ff;
                     ctr_in          = ctr_ff + 1'b1;
                     state_in        = S_RR;
                  end
                  S_RR: begin
                     produce         = 1'b1;
                     prod_res.kind   = RES_RR;
                     prod_res.number = exp_ff;
                     prod_res.ctrl   = ctr_ff;
                     ctr_in          = ctr_ff + 1'b1;
                     state_in = (flush_ff && (exp_ff - 1'b1 == hi_ff)) ? S_RR_CLR : S_EOF;
                  end
                  S_RR_CLR: begin
                     produce         = 1'b1;
                     prod_res.kind   = RES_RR;
                     prod_res.number = exp_ff;
                     prod_res.ctrl   = ctr_ff;
                     ctr_in          = ctr_ff + 1'b1;
                     buf_in          = 1'b0;
                     state_in        = S_EOF;
                  end
                  S_FL_CHK: begin
                     if (valid_ff[exp_mod_ff]) begin
                        valid_in[exp_mod_ff] = 1'b0;
                        mem_re               = 1'b1;
                        state_in             = S_FL_RD;
                     end else if (exp_ff < hi_ff) begin
                        state_in = S_SREJ;
                     end else if (exp_ff - 1'b1 == hi_ff) begin
                        state_in = S_RR_CLR;
                     end else begin
                        state_in = S_EOF;
                     end
                  end
                  S_FL_RD: begin
                     produce         = 1'b1;
                     prod_res.kind   = RES_DELIVER;
                     prod_res.number = exp_ff;
                     prod_res.handle = rd_data_ff[HANDLE_W+LEN_W-1:LEN_W];
                     prod_res.len    = rd_data_ff[LEN_W-1:0];
                     exp_in          = exp_ff + 1'b1;
                     exp_mod_in      = mod_inc;
                     state_in        = S_FL_CHK;
                  end
                  S_EOF: begin
                     if (!buf_ff && eofs_ff) begin
                        produce       = 1'b1;
                        prod_res.kind = RES_EOFACK;
                        prod_res.ctrl = ctr_ff;
                        fin_in        = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  S_DONE: begin
                     finish   = 1'b1;
                     state_in = S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
      endcase
      if (rem_stat.done) begin
         exp_mod_in = rem_stat.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         exp_ff     <= SEQ_W'(1);
         hi_ff      <= SEQ_W'(1);
         ctr_ff     <= SEQ_W'(1);
         buf_ff     <= 1'b0;
         eofs_ff    <= 1'b0;
         fin_ff     <= 1'b0;
         flush_ff   <= 1'b0;
         exp_mod_ff <= EXP_MOD_RST;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         exp_ff     <= exp_in;
         hi_ff      <= hi_in;
         ctr_ff     <= ctr_in;
         buf_ff     <= buf_in;
         eofs_ff    <= eofs_in;
         fin_ff     <= fin_in;
         flush_ff   <= flush_in;
         exp_mod_ff <= exp_mod_in;
         valid_ff   <= valid_in;
      end
   end

   // ------------------------------------------------------------------ window store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[slot_idx] <= {it_handle_ff, len_sat};
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[exp_mod_ff];
      end
   end

   // ------------------------------------------------------------------ result output
   // One result is held back so that the final beat of an item can carry last.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_accept) begin
         cnt_in = '0;
      end
      if (produce && (cnt_ff < CNT_W'(MAX_RESULTS))) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = prod_res;
         cnt_in        = cnt_ff + 1'b1;
      end else if (finish && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'b0, rsp_ff.len, rsp_ff.handle, rsp_ff.ctrl, rsp_ff.number};

`ifndef SYNTHESIS
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("held result left over after item closed");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count past limit");

   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("finished flag dropped");

   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FL_CHK && emit_ok && valid_ff[exp_mod_ff])
      |=> (state_ff == S_FL_RD && !valid_ff[$past(exp_mod_ff)]))
      else $error("flushed slot not released");
`endif

endmodule

`default_nettype wire
